@@ rtl/seven_segment_clock_scan_driver_assert.svh @@
// Assertion macros for the seven-segment scan driver.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef SEVEN_SEGMENT_CLOCK_SCAN_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_CLOCK_SCAN_DRIVER_ASSERT_SVH

// same-cycle implication
`define SSC_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssc assertion failed");

// next-cycle implication
`define SSC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssc assertion failed");

`endif

@@ rtl/ssc_pkg.sv @@
// Shared types, command codes and decode tables for the seven-segment scan driver.
// No dependencies.
package ssc_pkg;

   typedef enum logic [3:0] {
      CMD_SCAN      = 4'd0,
      CMD_SET_DIGIT = 4'd1,
      CMD_SET_COLON = 4'd2,
      CMD_TOG_COLON = 4'd3,
      CMD_LED_ON    = 4'd4,
      CMD_LED_OFF   = 4'd5,
      CMD_ROTATE    = 4'd6,
      CMD_SET_TIME  = 4'd7,
      CMD_MIN_TICK  = 4'd8
   } ssc_cmd_type;

   localparam int unsigned MinutesPerHour = 60;
   localparam int unsigned HoursPerDay    = 24;
   localparam int unsigned ReqDataW       = 24;
   localparam int unsigned RspDataW       = 32;

   typedef struct packed {
      logic [3:0] cmd;
      logic [3:0] digit_value;
      logic [1:0] digit_position;
      logic       dot_on;
      logic       colon_on;
      logic [1:0] led_select;
      logic [4:0] hours_in;
      logic [5:0] minutes_in;
   } ssc_item_type;

   typedef struct packed {
      logic            upd;
      logic [3:0][7:0] seg;
   } ssc_clock_type;

   // active-low segment patterns, dot is bit 0
   function automatic logic [7:0] seg_code(input logic [3:0] value);
      logic [7:0] code;
      case (value)
         4'd0: code = 8'h03;
         4'd1: code = 8'h9f;
         4'd2: code = 8'h25;
         4'd3: code = 8'h0d;
         4'd4: code = 8'h99;
         4'd5: code = 8'h49;
         4'd6: code = 8'h41;
         4'd7: code = 8'h1f;
         4'd8: code = 8'h01;
         4'd9: code = 8'h09;
         default: code = 8'hff;
      endcase
      return code;
   endfunction

   // active-low digit enables, frame bits 7..4
   function automatic logic [3:0] enable_nibble(input logic [1:0] idx);
      logic [3:0] nib;
      case (idx)
         2'd0: nib = 4'hb;
         2'd1: nib = 4'hd;
         2'd2: nib = 4'he;
         2'd3: nib = 4'h7;
         default: nib = 4'hf;
      endcase
      return nib;
   endfunction

   // tens digit of a value below 64: (x * 26) >> 8
   function automatic logic [3:0] tens_of(input logic [5:0] x);
      logic [10:0] prod;
      prod = 11'(x) * 11'd26;
      return {1'b0, prod[10:8]};
   endfunction

   function automatic logic [3:0] units_of(input logic [5:0] x);
      logic [6:0] t10;
      t10 = 7'(tens_of(x)) * 7'd10;
      return 4'(7'(x) - t10);
   endfunction

endpackage

@@ rtl/ssc_clock.sv @@
// Hours:minutes counter with 24-hour wrap and the HH MM digit patterns.
// Depends on ssc_pkg.
module ssc_clock (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ssc_pkg::ssc_item_type item,
   output logic [4:0]            hours_next,
   output logic [5:0]            minutes_next,
   output ssc_pkg::ssc_clock_type clk_upd
);
   import ssc_pkg::*;

   logic [4:0] hour_ff, hour_in;
   logic [5:0] minute_ff, minute_in;
   logic [6:0] min_inc;
   logic [5:0] hour_inc;

   always_comb begin
      hour_in   = hour_ff;
      minute_in = minute_ff;
      min_inc   = 7'(minute_ff) + 7'd1;
      hour_inc  = 6'(hour_ff) + 6'd1;
      clk_upd.upd = 1'b0;
      case (item.cmd)
         CMD_SET_TIME: begin
            hour_in     = item.hours_in;
            minute_in   = item.minutes_in;
            clk_upd.upd = 1'b1;
         end
         CMD_MIN_TICK: begin
            clk_upd.upd = 1'b1;
            if (min_inc >= 7'(MinutesPerHour)) begin
               minute_in = '0;
               if (hour_inc >= 6'(HoursPerDay)) begin
                  hour_in = '0;
               end else begin
                  hour_in = hour_inc[4:0];
               end
            end else begin
               minute_in = min_inc[5:0];
            end
         end
         default: begin
         end
      endcase
      clk_upd.seg[0] = seg_code(tens_of({1'b0, hour_in}));
      clk_upd.seg[1] = seg_code(units_of({1'b0, hour_in}));
      clk_upd.seg[2] = seg_code(tens_of(minute_in));
      clk_upd.seg[3] = seg_code(units_of(minute_in));
   end

   assign hours_next   = hour_in;
   assign minutes_next = minute_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff   <= '0;
         minute_ff <= '0;
      end else if (fire) begin
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
      end
   end

endmodule

@@ rtl/ssc_display.sv @@
// Digit patterns, scan index and frame word for the multiplexed display.
// Depends on ssc_pkg; takes clock digit updates from ssc_clock.
module ssc_display (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  ssc_pkg::ssc_item_type  item,
   input  ssc_pkg::ssc_clock_type clk_upd,
   output logic [15:0]            frame_next,
   output logic                   sent_next
);
   import ssc_pkg::*;

   logic [3:0][7:0] pat_ff, pat_in;
   logic [1:0]      idx_ff, idx_in;
   logic [15:0]     frame_ff, frame_in;
   logic [2:0]      led_mask;

   always_comb begin
      case (item.led_select)
         2'd0: led_mask = 3'b001;
         2'd1: led_mask = 3'b010;
         2'd2: led_mask = 3'b100;
         default: led_mask = 3'b000;
      endcase
   end

   always_comb begin
      pat_in    = pat_ff;
      idx_in    = idx_ff;
      frame_in  = frame_ff;
      sent_next = 1'b0;
      case (item.cmd)
         CMD_SCAN: begin
            frame_in  = {pat_ff[idx_ff], enable_nibble(idx_ff), frame_ff[3:0]};
            idx_in    = idx_ff + 2'd1;
            sent_next = 1'b1;
         end
         CMD_SET_DIGIT: begin
            if (item.digit_value <= 4'd9) begin
               pat_in[item.digit_position] = seg_code(item.digit_value) &
                                             ~{7'b0, item.dot_on};
            end
         end
         CMD_SET_COLON: frame_in[3] = ~item.colon_on;
         CMD_TOG_COLON: frame_in[3] = ~frame_ff[3];
         CMD_LED_ON:    frame_in[2:0] = frame_ff[2:0] | led_mask;
         CMD_LED_OFF:   frame_in[2:0] = frame_ff[2:0] & ~led_mask;
         CMD_ROTATE:    pat_in = {pat_ff[2], pat_ff[1], pat_ff[0], pat_ff[3]};
         default: begin
         end
      endcase
      if (clk_upd.upd) begin
         pat_in = clk_upd.seg;
      end
   end

   assign frame_next = frame_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff   <= {8'd3, 8'd2, 8'd1, 8'd0};
         idx_ff   <= '0;
         frame_ff <= '0;
      end else if (fire) begin
         pat_ff   <= pat_in;
         idx_ff   <= idx_in;
         frame_ff <= frame_in;
      end
   end

endmodule

@@ rtl/seven_segment_clock_scan_driver.sv @@
// Seven-segment scan driver with hours:minutes clock: an input register, the
// command logic and a result register. Takes one command word every clock
// cycle while the output is not stalled. A command word waits in the input
// register, and its result is written into the result register when the
// output can advance, so an output stall can come between the two. While a result
// waits on the output, the input side takes words only until the input
// register is full.
// Depends on ssc_pkg, ssc_clock, ssc_display and the assertion macro header.
module seven_segment_clock_scan_driver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [3:0] digit_value, [5:4] digit_position, [6] dot_on, [7] colon_on,
   // [9:8] led_select, [14:10] hours_in, [20:15] minutes_in, [23:21] zero
   input  logic [ssc_pkg::ReqDataW-1:0]  req_tdata,
   // [3:0] cmd
   input  logic [3:0]                    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [15:0] frame, [20:16] hours, [26:21] minutes, [31:27] zero
   output logic [ssc_pkg::RspDataW-1:0]  rsp_tdata,
   // [0] frame_sent
   output logic [0:0]                    rsp_tuser
);
   import ssc_pkg::*;
   `include "seven_segment_clock_scan_driver_assert.svh"

   ssc_item_type  item_ff, item_in;
   logic          in_valid_ff, in_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   frame_ff;
   logic          sent_ff;
   logic [4:0]    hours_ff;
   logic [5:0]    minutes_ff;
   logic          advance, fire, req_take;
   logic [15:0]   frame_next;
   logic          sent_next;
   logic [4:0]    hours_next;
   logic [5:0]    minutes_next;
   ssc_clock_type clk_upd;

   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign fire       = in_valid_ff & advance;
   assign req_tready = ~in_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   always_comb begin
      item_in.cmd            = req_tuser;
      item_in.digit_value    = req_tdata[3:0];
      item_in.digit_position = req_tdata[5:4];
      item_in.dot_on         = req_tdata[6];
      item_in.colon_on       = req_tdata[7];
      item_in.led_select     = req_tdata[9:8];
      item_in.hours_in       = req_tdata[14:10];
      item_in.minutes_in     = req_tdata[20:15];
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   ssc_clock u_clock (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (item_ff),
      .hours_next   (hours_next),
      .minutes_next (minutes_next),
      .clk_upd      (clk_upd)
   );

   ssc_display u_display (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (item_ff),
      .clk_upd    (clk_upd),
      .frame_next (frame_next),
      .sent_next  (sent_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (fire) begin
         frame_ff   <= frame_next;
         sent_ff    <= sent_next;
         hours_ff   <= hours_next;
         minutes_ff <= minutes_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, minutes_ff, hours_ff, frame_ff};
   assign rsp_tuser  = sent_ff;

   `SSC_ASSERT_NEXT(a_fire_gives_result, fire, rsp_valid_ff)
   `SSC_ASSERT_IMPL(a_scan_enable_code, rsp_valid_ff && sent_ff,
      frame_ff[7:4] == 4'hb || frame_ff[7:4] == 4'hd ||
      frame_ff[7:4] == 4'he || frame_ff[7:4] == 4'h7)
   `SSC_ASSERT_NEXT(a_tick_minute_range, fire && item_ff.cmd == CMD_MIN_TICK,
      minutes_ff < 6'(MinutesPerHour))

endmodule

@@ tb/tb_seven_segment_clock_scan_driver.sv @@
// Self-checking testbench for seven_segment_clock_scan_driver: directed table, then random
// commands under four idling phases, each checked by table row or in-bench display model.
// Depends on ssc_pkg and the RTL of the scan driver.
`timescale 1ns / 100ps

module tb_seven_segment_clock_scan_driver;
   import ssc_pkg::*;

   localparam logic [3:0] CmdUnusedFirst = 4'd9;
   localparam logic [3:0] CmdUnusedLast  = 4'd15;
   localparam logic [1:0] LedNone        = 2'd3;
   localparam int         IdleLimit      = 2000;
   localparam int         WordsPerPhase  = 225;

   typedef struct packed {
      logic [3:0] cmd;
      logic [3:0] digit_value;
      logic [1:0] digit_position;
      logic       dot_on;
      logic       colon_on;
      logic [1:0] led_select;
      logic [4:0] hours_in;
      logic [5:0] minutes_in;
   } cmd_word_type;

   typedef struct packed {
      logic [15:0] frame;
      logic        frame_sent;
      logic [4:0]  hours;
      logic [5:0]  minutes;
   } display_type;

   typedef struct packed {
      cmd_word_type word;
      logic         typed;
      display_type  display;
   } table_row_type;

   localparam logic [7:0] SegPattern [10] = '{
      8'h03, 8'h9f, 8'h25, 8'h0d, 8'h99, 8'h49, 8'h41, 8'h1f, 8'h01, 8'h09
   };
   localparam logic [3:0] DigitEnable [4] = '{4'hb, 4'hd, 4'he, 4'h7};

   localparam table_row_type DirectedRows [25] = '{
      '{'{CMD_SCAN,      4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0},
        1'b1, '{16'h00b0, 1'b1, 5'd0, 6'd0}},
      '{'{CMD_SCAN,      4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0},
        1'b1, '{16'h01d0, 1'b1, 5'd0, 6'd0}},
      '{'{CMD_SCAN,      4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0},
        1'b1, '{16'h02e0, 1'b1, 5'd0, 6'd0}},
      '{'{CMD_SCAN,      4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0},
        1'b1, '{16'h0370, 1'b1, 5'd0, 6'd0}},
      '{'{CMD_TOG_COLON, 4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0},
        1'b1, '{16'h0378, 1'b0, 5'd0, 6'd0}},
      '{'{CMD_LED_ON,    4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0},
        1'b1, '{16'h0379, 1'b0, 5'd0, 6'd0}},
      '{'{CMD_LED_ON,    4'd0,  2'd0, 1'b0, 1'b0, 2'd2,    5'd0,  6'd0},
        1'b1, '{16'h037d, 1'b0, 5'd0, 6'd0}},
      '{'{CMD_LED_ON,    4'd0,  2'd0, 1'b0, 1'b0, LedNone, 5'd0,  6'd0},
        1'b1, '{16'h037d, 1'b0, 5'd0, 6'd0}},
      '{'{CMD_LED_OFF,   4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0},
        1'b1, '{16'h037c, 1'b0, 5'd0, 6'd0}},
      '{'{CMD_LED_OFF,   4'd0,  2'd0, 1'b0, 1'b0, LedNone, 5'd0,  6'd0},
        1'b1, '{16'h037c, 1'b0, 5'd0, 6'd0}},
      '{'{CMD_SET_COLON, 4'd0,  2'd0, 1'b0, 1'b1, 2'd0,    5'd0,  6'd0},
        1'b1, '{16'h0374, 1'b0, 5'd0, 6'd0}},
      '{'{CMD_SET_COLON, 4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0},
        1'b1, '{16'h037c, 1'b0, 5'd0, 6'd0}},
      '{'{CMD_SET_DIGIT, 4'd9,  2'd0, 1'b1, 1'b0, 2'd0,    5'd0,  6'd0}, 1'b0, '0},
      '{'{CMD_SET_DIGIT, 4'd15, 2'd1, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0}, 1'b0, '0},
      '{'{CMD_SET_DIGIT, 4'd0,  2'd3, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0}, 1'b0, '0},
      '{'{CMD_ROTATE,    4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0}, 1'b0, '0},
      '{'{CMD_SET_TIME,  4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd23, 6'd59},
        1'b1, '{16'h037c, 1'b0, 5'd23, 6'd59}},
      '{'{CMD_MIN_TICK,  4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0},
        1'b1, '{16'h037c, 1'b0, 5'd0, 6'd0}},
      '{'{CMD_SCAN,      4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0}, 1'b0, '0},
      '{'{CMD_SET_TIME,  4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd31, 6'd63}, 1'b0, '0},
      '{'{CMD_SCAN,      4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0}, 1'b0, '0},
      '{'{CMD_MIN_TICK,  4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0}, 1'b0, '0},
      '{'{CmdUnusedFirst, 4'd0, 2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0}, 1'b0, '0},
      '{'{CMD_MIN_TICK,  4'd0,  2'd0, 1'b0, 1'b0, 2'd0,    5'd0,  6'd0}, 1'b0, '0},
      '{'{CmdUnusedLast, 4'd15, 2'd3, 1'b1, 1'b1, LedNone, 5'd31, 6'd63}, 1'b0, '0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [3:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   // display model state
   logic [7:0]  digit_segs [4];
   logic [1:0]  scan_slot;
   logic [15:0] frame_reg;
   logic [4:0]  clock_hours;
   logic [5:0]  clock_minutes;

   display_type pending_displays [$];
   int          errors;
   int          idle_cycles;
   int          send_gap_pct;
   int          stall_pct;

   seven_segment_clock_scan_driver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void write_digit(input logic [3:0] value, input logic [1:0] slot,
                                       input logic dot);
      logic [7:0] pattern;
      if (value <= 4'd9) begin
         pattern = SegPattern[value];
         if (dot) pattern[0] = 1'b0;
         digit_segs[slot] = pattern;
      end
   endfunction

   function automatic void show_time();
      write_digit(4'(clock_hours / 10), 2'd0, 1'b0);
      write_digit(4'(clock_hours % 10), 2'd1, 1'b0);
      write_digit(4'(clock_minutes / 10), 2'd2, 1'b0);
      write_digit(4'(clock_minutes % 10), 2'd3, 1'b0);
   endfunction

   function automatic display_type predict_display(input cmd_word_type w);
      display_type d;
      logic [15:0] f;
      logic [7:0]  wrapped;
      logic [6:0]  m;
      logic [5:0]  h;
      f = frame_reg;
      d.frame_sent = 1'b0;
      case (w.cmd)
         CMD_SCAN: begin
            f = {digit_segs[scan_slot], DigitEnable[scan_slot], f[3:0]};
            scan_slot = scan_slot + 2'd1;
            d.frame_sent = 1'b1;
         end
         CMD_SET_DIGIT: write_digit(w.digit_value, w.digit_position, w.dot_on);
         CMD_SET_COLON: f[3] = ~w.colon_on;
         CMD_TOG_COLON: f[3] = ~f[3];
         CMD_LED_ON: if (w.led_select != LedNone) f[w.led_select] = 1'b1;
         CMD_LED_OFF: if (w.led_select != LedNone) f[w.led_select] = 1'b0;
         CMD_ROTATE: begin
            wrapped = digit_segs[3];
            digit_segs[3] = digit_segs[2];
            digit_segs[2] = digit_segs[1];
            digit_segs[1] = digit_segs[0];
            digit_segs[0] = wrapped;
         end
         CMD_SET_TIME: begin
            clock_hours = w.hours_in;
            clock_minutes = w.minutes_in;
            show_time();
         end
         CMD_MIN_TICK: begin
            m = 7'(clock_minutes) + 7'd1;
            h = 6'(clock_hours);
            if (m >= 7'(MinutesPerHour)) begin
               m = '0;
               h = h + 6'd1;
               if (h >= 6'(HoursPerDay)) h = '0;
            end
            clock_minutes = m[5:0];
            clock_hours = h[4:0];
            show_time();
         end
         default: ;
      endcase
      frame_reg = f;
      d.frame = f;
      d.hours = clock_hours;
      d.minutes = clock_minutes;
      return d;
   endfunction

   function automatic cmd_word_type random_word();
      cmd_word_type w;
      int pick;
      w.digit_value = 4'($urandom_range(9));
      if ($urandom_range(5) == 0) w.digit_value = 4'($urandom_range(15));
      w.digit_position = 2'($urandom_range(3));
      w.dot_on = 1'($urandom_range(1));
      w.colon_on = 1'($urandom_range(1));
      w.led_select = 2'($urandom_range(3));
      w.hours_in = 5'($urandom_range(23));
      w.minutes_in = 6'($urandom_range(59));
      pick = $urandom_range(9);
      if (pick == 0) begin
         w.hours_in = 5'($urandom_range(31));
         w.minutes_in = 6'($urandom_range(63));
      end else if (pick < 4) begin
         // close to midnight so ticks reach the day wrap
         w.hours_in = 5'($urandom_range(23, 22));
         w.minutes_in = 6'($urandom_range(59, 55));
      end
      pick = $urandom_range(99);
      if (pick < 25) w.cmd = CMD_SCAN;
      else if (pick < 35) w.cmd = CMD_SET_DIGIT;
      else if (pick < 42) w.cmd = CMD_SET_COLON;
      else if (pick < 48) w.cmd = CMD_TOG_COLON;
      else if (pick < 55) w.cmd = CMD_LED_ON;
      else if (pick < 62) w.cmd = CMD_LED_OFF;
      else if (pick < 70) w.cmd = CMD_ROTATE;
      else if (pick < 76) w.cmd = CMD_SET_TIME;
      else if (pick < 93) w.cmd = CMD_MIN_TICK;
      else w.cmd = 4'($urandom_range(CmdUnusedLast, CmdUnusedFirst));
      return w;
   endfunction

   task automatic send_word(input cmd_word_type w, input logic typed, input display_type known);
      display_type d;
      @(negedge clock);
      while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, w.minutes_in, w.hours_in, w.led_select, w.colon_on, w.dot_on,
                    w.digit_position, w.digit_value};
      req_tuser <= w.cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      d = predict_display(w);
      pending_displays.push_back(typed ? known : d);
   endtask

   task automatic drain_displays();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_displays.size() != 0) @(posedge clock);
   endtask

   // response side: random stall, check on each accepted word
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      display_type got;
      display_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.frame = rsp_tdata[15:0];
         got.hours = rsp_tdata[20:16];
         got.minutes = rsp_tdata[26:21];
         got.frame_sent = rsp_tuser[0];
         if (pending_displays.size() == 0) begin
            $display("%0t: unexpected word, got %h", $time, got);
            errors++;
         end else begin
            want = pending_displays.pop_front();
            if (got.frame !== want.frame) begin
               $display("%0t: frame expected %h got %h", $time, want.frame, got.frame);
               errors++;
            end
            if (got.frame_sent !== want.frame_sent) begin
               $display("%0t: frame_sent expected %b got %b", $time, want.frame_sent,
                        got.frame_sent);
               errors++;
            end
            if (got.hours !== want.hours) begin
               $display("%0t: hours expected %0d got %0d", $time, want.hours, got.hours);
               errors++;
            end
            if (got.minutes !== want.minutes) begin
               $display("%0t: minutes expected %0d got %0d", $time, want.minutes,
                        got.minutes);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      int phase_gap [4];
      int phase_stall [4];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      errors = 0;
      idle_cycles = 0;
      send_gap_pct = 0;
      stall_pct = 0;
      phase_gap = '{0, 60, 0, 8};
      phase_stall = '{0, 0, 60, 8};
      for (int i = 0; i < 4; i++) digit_segs[i] = 8'(i);
      scan_slot = '0;
      frame_reg = '0;
      clock_hours = '0;
      clock_minutes = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DirectedRows[i])
         send_word(DirectedRows[i].word, DirectedRows[i].typed, DirectedRows[i].display);
      drain_displays();

      for (int p = 0; p < 4; p++) begin
         send_gap_pct = phase_gap[p];
         stall_pct = phase_stall[p];
         for (int n = 0; n < WordsPerPhase; n++) send_word(random_word(), 1'b0, '0);
         drain_displays();
      end

      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
